// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the checked integer ALU.
// Self-contained; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CIA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("checked ALU assertion failed");

// next-cycle implication
`define CIA_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("checked ALU assertion failed");

`endif

// ===== rtl/cia_pkg.sv =====
// Package for the checked integer ALU: operation and status codes,
// shared-unit mode and control struct. No dependencies.
package cia_pkg;

   typedef enum logic [2:0] {
      FUNC_ADD = 3'd0,
      FUNC_SUB = 3'd1,
      FUNC_MUL = 3'd2,
      FUNC_DIV = 3'd3,
      FUNC_MOD = 3'd4,
      FUNC_POW = 3'd5
   } func_type;

   typedef enum logic [2:0] {
      ST_OK     = 3'd0,
      ST_OVF    = 3'd1,
      ST_DIV0   = 3'd2,
      ST_NEGEXP = 3'd3,
      ST_BADOP  = 3'd4
   } status_type;

   typedef enum logic {
      UNIT_MUL = 1'b0,
      UNIT_DIV = 1'b1
   } unit_mode_type;

   typedef struct packed {
      logic          load;
      logic          step;
      unit_mode_type mode;
   } unit_ctrl_type;

endpackage

// ===== rtl/cia_shift_unit.sv =====
// Shared shift-add/subtract unit: one multiply or restoring divide step
// per cycle when stepped, on a 2*W-bit accumulator. Depends on cia_pkg.
module cia_shift_unit #(
   parameter int DATA_WIDTH = 64
) (
   input  logic                      clock,
   input  cia_pkg::unit_ctrl_type    ctrl,
   input  logic [DATA_WIDTH-1:0]     load_lo,
   input  logic [DATA_WIDTH-1:0]     operand,
   output logic [2*DATA_WIDTH-1:0]   acc
);
   localparam int W = DATA_WIDTH;

   logic [2*W-1:0] acc_ff, acc_in;
   logic [W-1:0]   hi;
   logic [W:0]     rem_sh;
   logic [W+1:0]   opx, opy, sum;
   logic           cin;

   always_comb begin
      hi     = acc_ff[2*W-1:W];
      rem_sh = {hi, acc_ff[W-1]};
      if (ctrl.mode == cia_pkg::UNIT_DIV) begin
         opx = {1'b0, rem_sh};
         opy = ~{2'b00, operand};
         cin = 1'b1;
      end else begin
         opx = {2'b00, hi};
         opy = acc_ff[0] ? {2'b00, operand} : '0;
         cin = 1'b0;
      end
      sum = opx + opy + {{(W+1){1'b0}}, cin};
      if (ctrl.mode == cia_pkg::UNIT_DIV) begin
         if (sum[W+1])
            acc_in = {rem_sh[W-1:0], acc_ff[W-2:0], 1'b0};
         else
            acc_in = {sum[W-1:0], acc_ff[W-2:0], 1'b1};
      end else begin
         acc_in = {sum[W:0], acc_ff[W-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load)
         acc_ff <= {{W{1'b0}}, load_lo};
      else if (ctrl.step)
         acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

// ===== rtl/checked_integer_alu.sv =====
// Checked integer ALU: add, sub, mul, div, mod, pow with overflow status.
// Add, sub and special cases finish in S_EVAL; mul steps in S_MUL, then S_CHK;
// div and mod step in S_DIV, then S_DFIN; pow repeats S_MUL and S_CHK per factor.
// Steps run on the one shared shift-add/subtract unit, one bit per cycle.
// One item at a time; busy stays high until the result strobe.
// Synchronous reset clears the sequencer and the strobe; the receiver cannot stall.
module checked_integer_alu #(
   parameter int DATA_WIDTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_func,
   input  logic [63:0] req_operand_a,
   input  logic [63:0] req_operand_b,
   output logic        rsp_valid,
   output logic [63:0] rsp_value,
   output logic [2:0]  rsp_status
);
   `include "assert_macros.svh"

   localparam int W  = DATA_WIDTH;
   localparam int CW = $clog2(DATA_WIDTH + 1);
   localparam logic [2*W-1:0] TOP2 = (2*W)'(1) << (W - 1);

   typedef enum logic [2:0] {
      S_IDLE, S_EVAL, S_MUL, S_CHK, S_DIV, S_DFIN
   } state_type;

   state_type                state_ff, state_in;
   cia_pkg::func_type        func_ff, func_in;
   logic [W-1:0]             a_ff, a_in, b_ff, b_in, mag_ff, mag_in, exp_ff, exp_in;
   logic                     neg_ff, neg_in;
   logic [CW-1:0]            cnt_ff, cnt_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [63:0]              rsp_value_ff, rsp_value_in;
   cia_pkg::status_type      rsp_status_ff, rsp_status_in;

   cia_pkg::unit_ctrl_type   ctrl;
   logic [W-1:0]             load_lo;
   logic [2*W-1:0]           acc;

   logic                     a_neg, b_neg, fin;
   logic [W-1:0]             a_abs, b_abs, min_w, p_lo, q, r, fin_val;
   logic [W:0]               sum_add, sum_sub;
   logic [2*W-1:0]           lim;
   cia_pkg::status_type      fin_st;

   cia_shift_unit #(.DATA_WIDTH(W)) u_unit (
      .clock   (clock),
      .ctrl    (ctrl),
      .load_lo (load_lo),
      .operand (mag_ff),
      .acc     (acc)
   );

   always_comb begin
      a_neg   = a_ff[W-1];
      b_neg   = b_ff[W-1];
      a_abs   = a_neg ? (W'(0) - a_ff) : a_ff;
      b_abs   = b_neg ? (W'(0) - b_ff) : b_ff;
      min_w   = {1'b1, {(W-1){1'b0}}};
      sum_add = {a_ff[W-1], a_ff} + {b_ff[W-1], b_ff};
      sum_sub = {a_ff[W-1], a_ff} - {b_ff[W-1], b_ff};
      p_lo    = acc[W-1:0];
      q       = acc[W-1:0];
      r       = acc[2*W-1:W];
      lim     = neg_ff ? TOP2 : (TOP2 - (2*W)'(1));

      state_in = state_ff;
      func_in  = func_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      mag_in   = mag_ff;
      exp_in   = exp_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      ctrl     = '{load: 1'b0, step: 1'b0, mode: cia_pkg::UNIT_MUL};
      load_lo  = '0;
      fin      = 1'b0;
      fin_st   = cia_pkg::ST_OK;
      fin_val  = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               func_in  = cia_pkg::func_type'(req_func);
               a_in     = req_operand_a[W-1:0];
               b_in     = req_operand_b[W-1:0];
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            case (func_ff)
               cia_pkg::FUNC_ADD: begin
                  fin = 1'b1;
                  if (sum_add[W] != sum_add[W-1]) fin_st = cia_pkg::ST_OVF;
                  else fin_val = sum_add[W-1:0];
               end
               cia_pkg::FUNC_SUB: begin
                  fin = 1'b1;
                  if (sum_sub[W] != sum_sub[W-1]) fin_st = cia_pkg::ST_OVF;
                  else fin_val = sum_sub[W-1:0];
               end
               cia_pkg::FUNC_MUL: begin
                  ctrl.load = 1'b1;
                  load_lo   = b_abs;
                  mag_in    = a_abs;
                  neg_in    = a_neg ^ b_neg;
                  exp_in    = W'(1);
                  cnt_in    = CW'(W);
                  state_in  = S_MUL;
               end
               cia_pkg::FUNC_DIV, cia_pkg::FUNC_MOD: begin
                  if (b_ff == '0) begin
                     fin    = 1'b1;
                     fin_st = cia_pkg::ST_DIV0;
                  end else if (a_ff == min_w && b_ff == '1) begin
                     fin    = 1'b1;
                     fin_st = cia_pkg::ST_OVF;
                  end else begin
                     ctrl.load = 1'b1;
                     load_lo   = a_abs;
                     mag_in    = b_abs;
                     neg_in    = a_neg ^ b_neg;
                     cnt_in    = CW'(W);
                     state_in  = S_DIV;
                  end
               end
               cia_pkg::FUNC_POW: begin
                  if (b_neg) begin
                     fin    = 1'b1;
                     fin_st = cia_pkg::ST_NEGEXP;
                  end else if (a_ff == '0) begin
                     fin     = 1'b1;
                     fin_val = (b_ff == '0) ? W'(1) : W'(0);
                  end else if (a_ff == W'(1) || b_ff == '0) begin
                     fin     = 1'b1;
                     fin_val = W'(1);
                  end else if (a_ff == '1) begin
                     fin     = 1'b1;
                     fin_val = b_ff[0] ? '1 : W'(1);
                  end else begin
                     ctrl.load = 1'b1;
                     load_lo   = W'(1);
                     mag_in    = a_abs;
                     neg_in    = a_neg;
                     exp_in    = b_ff;
                     cnt_in    = CW'(W);
                     state_in  = S_MUL;
                  end
               end
               default: begin
                  fin    = 1'b1;
                  fin_st = cia_pkg::ST_BADOP;
               end
            endcase
         end
         S_MUL: begin
            ctrl.step = 1'b1;
            ctrl.mode = cia_pkg::UNIT_MUL;
            cnt_in    = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) state_in = S_CHK;
         end
         S_CHK: begin
            if (acc > lim) begin
               fin    = 1'b1;
               fin_st = cia_pkg::ST_OVF;
            end else if (exp_ff == W'(1)) begin
               fin     = 1'b1;
               fin_val = neg_ff ? (W'(0) - p_lo) : p_lo;
            end else begin
               exp_in    = exp_ff - W'(1);
               neg_in    = neg_ff ^ a_neg;
               ctrl.load = 1'b1;
               load_lo   = p_lo;
               cnt_in    = CW'(W);
               state_in  = S_MUL;
            end
         end
         S_DIV: begin
            ctrl.step = 1'b1;
            ctrl.mode = cia_pkg::UNIT_DIV;
            cnt_in    = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) state_in = S_DFIN;
         end
         S_DFIN: begin
            fin = 1'b1;
            if (func_ff == cia_pkg::FUNC_DIV) fin_val = neg_ff ? (W'(0) - q) : q;
            else fin_val = a_neg ? (W'(0) - r) : r;
         end
         default: state_in = S_IDLE;
      endcase

      if (fin) state_in = S_IDLE;
      rsp_valid_in  = fin;
      rsp_status_in = fin ? fin_st : rsp_status_ff;
      if (fin)
         rsp_value_in = (fin_st == cia_pkg::ST_OK) ? 64'($signed(fin_val)) : 64'd0;
      else
         rsp_value_in = rsp_value_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff       <= func_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      mag_ff        <= mag_in;
      exp_ff        <= exp_in;
      neg_ff        <= neg_in;
      cnt_ff        <= cnt_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

   `CIA_ASSERT_NXT(a_busy_after_accept, clock, reset, start && !busy, busy)
   `CIA_ASSERT_IMP(a_idle_on_strobe, clock, reset, rsp_valid_ff, !busy)
   `CIA_ASSERT_IMP(a_zero_on_error, clock, reset,
      rsp_valid_ff && rsp_status_ff != cia_pkg::ST_OK, rsp_value_ff == 64'd0)
   `CIA_ASSERT_NXT(a_single_strobe, clock, reset, rsp_valid_ff, !rsp_valid_ff)

endmodule
